FILE: sv/assert_macros.svh
// Assertion macros shared by the classifier RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define BLC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("check failed");

// Check a property on every rising edge, reset included
`define BLC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("check failed");

`endif

FILE: sv/blc_pkg.sv
// Package for the block linear complexity classifier: word types,
// category thresholds and the deviation classifier. No dependencies.
`default_nettype none
package blc_pkg;

  typedef struct packed {
    logic data_bit;
    logic sequence_end;
  } blc_in_t;

  typedef struct packed {
    logic [9:0]  linear_complexity;
    logic [2:0]  category;
    logic [15:0] block_number;
  } blc_out_t;

  localparam logic [9:0] BLOCK_LEN_RESET = 10'd500;
  localparam logic [15:0] BLOCK_LEN_MIN  = 16'd2;

  // Category boundaries on 36*T
  localparam logic signed [19:0] TH_0 = -20'sd90;
  localparam logic signed [19:0] TH_1 = -20'sd54;
  localparam logic signed [19:0] TH_2 = -20'sd18;
  localparam logic signed [19:0] TH_3 = 20'sd18;
  localparam logic signed [19:0] TH_4 = 20'sd54;
  localparam logic signed [19:0] TH_5 = 20'sd90;

  // 36*T = s*(36L - 18M - (9+s)) + 8, s = +1 for even M, -1 for odd M
  function automatic logic [2:0] classify(input logic [15:0] lc, input logic [15:0] m);
    logic signed [19:0] l36;
    logic signed [19:0] m18;
    logic signed [19:0] x;
    logic [2:0]         cat;
    l36 = $signed({4'b0, lc}) * 20'sd36;
    m18 = $signed({4'b0, m}) * 20'sd18;
    if (m[0] == 1'b0) begin
      x = l36 - m18 - 20'sd2;
    end else begin
      x = m18 - l36 + 20'sd16;
    end
    if (x <= TH_0)      cat = 3'd0;
    else if (x <= TH_1) cat = 3'd1;
    else if (x <= TH_2) cat = 3'd2;
    else if (x <= TH_3) cat = 3'd3;
    else if (x <= TH_4) cat = 3'd4;
    else if (x <= TH_5) cat = 3'd5;
    else                cat = 3'd6;
    return cat;
  endfunction

endpackage
`default_nettype wire

FILE: sv/block_linear_complexity_classifier.sv
// Block linear complexity classifier: Berlekamp-Massey over GF(2) per block.
// Depends on blc_pkg and assert_macros.svh.
//
//   channel   ports                              direction
//   input     in_valid / in_ready / in_data      bit words in
//   result    out_valid / out_ready / out_data   one word per finished block
//   config    cfg_we / cfg_wdata                 block length, no wait
//
// Each bit runs a discrepancy sweep over min(L, pos) taps after acceptance,
// plus a polynomial update sweep up to the new extent when the discrepancy
// is one; the next bit is taken only when both sweeps are done.
// Reset is synchronous; no memory clearing pass, extents mark the live entries.
// A finished word waits in the output register; a new bit is taken meanwhile,
// but the next finished block holds the input until that word is taken.
`include "assert_macros.svh"
`default_nettype none
module block_linear_complexity_classifier import blc_pkg::*; #(
  parameter int MAX_BLOCK_BITS = 512
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire blc_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output blc_out_t      out_data,
  input  wire logic     cfg_we,
  input  wire logic [9:0] cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_BLOCK_BITS);
  localparam int CNT_W = $clog2(MAX_BLOCK_BITS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCK_BITS);
  localparam logic [15:0] MAX_16 = 16'(MAX_BLOCK_BITS);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DISC = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t               state_r;
  logic [9:0]           blen_r;
  logic                 send_r;
  logic [CNT_W-1:0]     m_r;
  logic [IDX_W-1:0]     pos_r;
  logic [CNT_W-1:0]     lc_r;
  logic signed [CNT_W:0] lcp_r;
  logic [CNT_W-1:0]     c_ext_r;
  logic [CNT_W-1:0]     b_ext_r;
  logic [15:0]          blk_cnt_r;
  logic                 d_r;
  logic [CNT_W-1:0]     i_r;
  logic [CNT_W-1:0]     n_r;
  logic                 rv_r;
  logic                 rcv_r;
  logic [IDX_W-1:0]     k_r;
  logic                 kgo_r;
  logic [CNT_W-1:0]     sh_r;
  logic [CNT_W-1:0]     oc_r;
  logic [CNT_W-1:0]     ob_r;
  logic                 swap_r;
  logic                 pv_r;
  logic [IDX_W-1:0]     pk_r;
  logic                 pcv_r;
  logic                 pb1_r;
  logic                 pbm_r;
  logic                 out_valid_r;
  blc_out_t             out_data_r;

  // Memories: connection poly, previous poly, block bits
  logic c_mem [MAX_BLOCK_BITS];
  logic b_mem [MAX_BLOCK_BITS];
  logic x_mem [MAX_BLOCK_BITS];
  logic c_q, b_q, x_q;
  logic [IDX_W-1:0] c_ra, b_ra, x_ra;
  logic c_we, b_we, x_we;
  logic c_wd, b_wd;

  logic             accept;
  logic [15:0]      len16;
  logic [CNT_W-1:0] m_eff;
  logic             disc_issue;
  logic             disc_done;
  logic [CNT_W:0]   sh_full;
  logic [CNT_W-1:0] sh_now;
  logic [CNT_W:0]   reach;
  logic [CNT_W:0]   tgt;
  logic [CNT_W-1:0] new_ext;
  logic             swap_now;
  logic [CNT_W-1:0] pos_c;
  logic [CNT_W-1:0] pos1;
  logic             fin_done;
  logic             fin_stall;
  logic [CNT_W-1:0] k_c;
  logic             cval, bval;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Clamp the configured length into 2..MAX_BLOCK_BITS
  always_comb begin
    len16 = {6'b0, blen_r};
    if (len16 < BLOCK_LEN_MIN) len16 = BLOCK_LEN_MIN;
    if (len16 > MAX_16)        len16 = MAX_16;
    m_eff = CNT_W'(len16);
  end

  // Discrepancy sweep control
  assign pos_c      = CNT_W'(pos_r);
  assign disc_issue = (i_r <= n_r);
  assign disc_done  = !disc_issue && !rv_r;

  // Update decision taken as the discrepancy sweep ends
  always_comb begin
    sh_full  = {1'b0, pos_c} - lcp_r;
    sh_now   = sh_full[CNT_W-1:0];
    reach    = {1'b0, sh_now} + {1'b0, b_ext_r};
    tgt      = ({1'b0, c_ext_r} > reach) ? {1'b0, c_ext_r} : reach;
    new_ext  = (tgt > {1'b0, MAX_CNT}) ? MAX_CNT : tgt[CNT_W-1:0];
    swap_now = ({1'b0, lc_r} << 1) <= {1'b0, pos_c};
  end

  // Block end check
  assign pos1      = pos_c + 1'b1;
  assign fin_done  = (pos1 >= m_r);
  assign fin_stall = fin_done && out_valid_r && !out_ready;

  // Memory addresses and write data
  assign k_c  = CNT_W'(k_r);
  assign cval = c_q & pcv_r;
  assign bval = pb1_r | (b_q & pbm_r);
  always_comb begin
    c_ra = i_r[IDX_W-1:0];
    if (state_r == ST_UPD) c_ra = k_r;
    b_ra = k_r - sh_r[IDX_W-1:0];
    x_ra = pos_r - i_r[IDX_W-1:0];
    c_we = (state_r == ST_UPD) && pv_r;
    c_wd = cval ^ bval;
    b_we = (state_r == ST_UPD) && pv_r && swap_r;
    b_wd = cval;
    x_we = accept;
  end

  // Synchronous memories with registered read data
  always_ff @(posedge clk) begin
    if (c_we) c_mem[pk_r] <= c_wd;
    c_q <= c_mem[c_ra];
  end

  always_ff @(posedge clk) begin
    if (b_we) b_mem[pk_r] <= b_wd;
    b_q <= b_mem[b_ra];
  end

  always_ff @(posedge clk) begin
    if (x_we) x_mem[pos_r] <= in_data.data_bit;
    x_q <= x_mem[x_ra];
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blen_r <= BLOCK_LEN_RESET;
    end else if (cfg_we) begin
      blen_r <= cfg_wdata;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && !fin_stall && fin_done) begin
      out_data_r.linear_complexity <= 10'(lc_r);
      out_data_r.category          <= classify(16'(lc_r), 16'(m_r));
      out_data_r.block_number      <= blk_cnt_r;
    end
  end

  // Sweep pipeline payload
  always_ff @(posedge clk) begin
    if (accept) begin
      send_r <= in_data.sequence_end;
      m_r    <= m_eff;
      n_r    <= (lc_r < pos_c) ? lc_r : pos_c;
    end
    rcv_r <= (i_r < c_ext_r);
    pk_r  <= k_r;
    pcv_r <= (k_c < oc_r);
    pb1_r <= (k_c == sh_r);
    pbm_r <= (k_c > sh_r) && ((k_c - sh_r) < ob_r);
    if (state_r == ST_DISC && disc_done && d_r) begin
      sh_r   <= sh_now;
      oc_r   <= c_ext_r;
      ob_r   <= b_ext_r;
      swap_r <= swap_now;
      k_r    <= IDX_W'(new_ext - 1'b1);
    end else if (state_r == ST_UPD && kgo_r) begin
      k_r <= k_r - 1'b1;
    end
  end

  // Control: sequencer, BM scalars, extents, counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      lc_r        <= '0;
      lcp_r       <= '1;
      c_ext_r     <= CNT_W'(1);
      b_ext_r     <= CNT_W'(1);
      blk_cnt_r   <= '0;
      d_r         <= 1'b0;
      i_r         <= '0;
      rv_r        <= 1'b0;
      kgo_r       <= 1'b0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the output word once taken
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            d_r     <= in_data.data_bit;
            i_r     <= CNT_W'(1);
            rv_r    <= 1'b0;
            state_r <= ST_DISC;
          end
        end
        ST_DISC: begin
          // advance the sweep, fold in last cycle's read
          rv_r <= disc_issue;
          if (disc_issue) i_r <= i_r + 1'b1;
          if (rv_r) d_r <= d_r ^ (c_q & x_q & rcv_r);
          if (disc_done) begin
            if (d_r) begin
              c_ext_r <= new_ext;
              if (swap_now) begin
                lc_r    <= pos1 - lc_r;
                lcp_r   <= $signed({1'b0, pos_c});
                b_ext_r <= c_ext_r;
              end
              kgo_r   <= 1'b1;
              pv_r    <= 1'b0;
              state_r <= ST_UPD;
            end else begin
              state_r <= ST_FIN;
            end
          end
        end
        ST_UPD: begin
          // descending sweep keeps the previous-poly reads ahead of the writes
          pv_r <= kgo_r;
          if (kgo_r && k_r == IDX_W'(1)) kgo_r <= 1'b0;
          if (!kgo_r && !pv_r) state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (!fin_stall) begin
            if (fin_done) begin
              out_valid_r <= 1'b1;
              blk_cnt_r   <= blk_cnt_r + 1'b1;
              pos_r       <= '0;
              lc_r        <= '0;
              lcp_r       <= '1;
              c_ext_r     <= CNT_W'(1);
              b_ext_r     <= CNT_W'(1);
            end else begin
              pos_r <= pos1[IDX_W-1:0];
            end
            if (send_r) begin
              pos_r     <= '0;
              lc_r      <= '0;
              lcp_r     <= '1;
              c_ext_r   <= CNT_W'(1);
              b_ext_r   <= CNT_W'(1);
              blk_cnt_r <= '0;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Complexity never runs ahead of the bits taken in the block
  `BLC_ASSERT(a_lc_bound, clk, rst_n, (state_r == ST_IDLE) |-> (lc_r <= pos_c))
  // Previous poly is an older connection poly, so its extent is no larger
  `BLC_ASSERT(a_ext_order, clk, rst_n, (b_ext_r <= c_ext_r) && (c_ext_r <= MAX_CNT))
  // A finished block always lands in the output register
  `BLC_ASSERT(a_emit, clk, rst_n, (state_r == ST_FIN && fin_done && !fin_stall) |=> out_valid_r)

endmodule
`default_nettype wire

FILE: tb/sv/tb_block_linear_complexity_classifier.sv
// Testbench for the block linear complexity classifier: streams bits with
// random gaps and stalls, predicts each block's complexity, category and index.
// Depends on blc_pkg and the block_linear_complexity_classifier RTL.
`timescale 1ns / 1ps
module tb_block_linear_complexity_classifier;
  import blc_pkg::*;

  localparam int MAXB = 512;
  localparam int WATCHDOG = 200000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  blc_in_t in_data;
  logic out_valid;
  logic out_ready;
  blc_out_t out_data;
  logic cfg_we;
  logic [9:0] cfg_wdata;

  block_linear_complexity_classifier dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Predictor state
  logic [9:0] len_reg;
  bit conn_poly [MAXB];
  bit prev_poly [MAXB];
  bit seen_bits [MAXB];
  int unsigned lin_cplx;
  int last_change;
  int unsigned bit_pos;
  logic [15:0] blk_count;

  blc_in_t pending_words[$];
  blc_out_t expected_words[$];
  int errors;
  int idle_pct_in;
  int idle_pct_out;
  int hold_off;
  bit sender_pause;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic void clear_bm();
    for (int k = 0; k < MAXB; k++) begin
      conn_poly[k] = 0;
      prev_poly[k] = 0;
    end
    conn_poly[0] = 1;
    prev_poly[0] = 1;
    lin_cplx = 0;
    last_change = -1;
    bit_pos = 0;
  endfunction

  function automatic logic [2:0] deviation_bin(input int lc, input int m);
    int s;
    int x;
    s = (m % 2 == 0) ? 1 : -1;
    x = s * (36 * lc - 18 * m - (9 + s)) + 8;
    if (x <= -90) return 3'd0;
    if (x <= -54) return 3'd1;
    if (x <= -18) return 3'd2;
    if (x <= 18) return 3'd3;
    if (x <= 54) return 3'd4;
    if (x <= 90) return 3'd5;
    return 3'd6;
  endfunction

  // Run one Berlekamp-Massey step and queue the block result if it closes
  function automatic void predict_bit(input blc_in_t w);
    int m;
    int unsigned pos;
    int unsigned shift;
    bit d;
    bit tmp [MAXB];
    blc_out_t r;
    m = len_reg;
    if (m < 2) m = 2;
    if (m > MAXB) m = MAXB;
    pos = (bit_pos >= MAXB) ? MAXB - 1 : bit_pos;
    seen_bits[pos] = w.data_bit;
    d = w.data_bit;
    for (int unsigned i = 1; i <= lin_cplx && i <= pos; i++)
      d ^= conn_poly[i] & seen_bits[pos - i];
    if (d) begin
      shift = pos - last_change;
      tmp = conn_poly;
      for (int unsigned j = 0; j + shift < MAXB; j++)
        conn_poly[j + shift] ^= prev_poly[j];
      if (2 * lin_cplx <= pos) begin
        lin_cplx = pos + 1 - lin_cplx;
        last_change = pos;
        prev_poly = tmp;
      end
    end
    bit_pos = pos + 1;
    if (bit_pos >= m) begin
      r.linear_complexity = lin_cplx[9:0];
      r.category = deviation_bin(lin_cplx, m);
      r.block_number = blk_count;
      expected_words.push_back(r);
      blk_count++;
      clear_bm();
    end
    if (w.sequence_end) begin
      clear_bm();
      blk_count = 0;
    end
  endfunction

  // Driver: offer queued words, idle at random
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) predict_bit(in_data);
      if (pending_words.size() > 0 && !sender_pause &&
          $urandom_range(99) >= idle_pct_in) begin
        in_data <= pending_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor and receiver: check words, stall at random or for a long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report("unexpected word", out_data.linear_complexity, 0);
        end else begin
          blc_out_t e;
          e = expected_words.pop_front();
          if (out_data.linear_complexity !== e.linear_complexity)
            report("linear_complexity", out_data.linear_complexity, e.linear_complexity);
          if (out_data.category !== e.category)
            report("category", out_data.category, e.category);
          if (out_data.block_number !== e.block_number)
            report("block_number", out_data.block_number, e.block_number);
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= idle_pct_out);
      end
      // Count cycles with nothing accepted
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid || expected_words.size() > 0)
      @(posedge clk);
    // sweeps may still run on a bit that closes no block
    repeat (2 * MAXB + 20) @(posedge clk);
  endtask

  // Hold until the offered word is taken and every expected word is in
  task automatic wait_results();
    while (in_valid || expected_words.size() > 0)
      @(posedge clk);
  endtask

  task automatic set_length(input logic [9:0] v);
    wait_drained();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    len_reg = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void queue_word(input bit b, input bit e);
    blc_in_t w;
    w.data_bit = b;
    w.sequence_end = e;
    pending_words.push_back(w);
  endfunction

  // Queue a run of random bits, ending the sequence now and then
  function automatic void queue_random(input int n, input int end_pct);
    for (int k = 0; k < n; k++)
      queue_word($urandom_range(1), $urandom_range(99) < end_pct);
  endfunction

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    errors = 0;
    idle_pct_in = 29;
    idle_pct_out = 29;
    hold_off = 0;
    sender_pause = 0;
    len_reg = BLOCK_LEN_RESET;
    blk_count = 0;
    for (int k = 0; k < MAXB; k++) seen_bits[k] = 0;
    clear_bm();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset length, a few bits then sequence end drops the block
    queue_word(1, 0); queue_word(0, 0); queue_word(1, 1);
    set_length(10'd0);
    // Length below minimum acts as 2; all-ones, all-zeros, end on a closing bit
    queue_word(0, 0); queue_word(0, 0); queue_word(1, 0); queue_word(1, 0);
    queue_word(1, 0); queue_word(0, 1); queue_word(1, 0); queue_word(1, 0);
    set_length(10'd1);
    queue_word(1, 0); queue_word(0, 0);
    set_length(10'd3);
    queue_word(0, 0); queue_word(0, 0); queue_word(0, 0);
    queue_word(0, 0); queue_word(0, 0); queue_word(1, 0);
    // Mid-block length change: shrink from 3 to 2 with one bit taken
    queue_word(1, 0);
    set_length(10'd2);
    queue_word(0, 0);
    // Long block at reset length with a random fill
    set_length(10'd500);
    queue_random(500, 0);
    set_length(10'd1023);
    queue_random(515, 0);

    // Random phases over several lengths, long no-idle stretch in one
    set_length(10'd7);
    idle_pct_in = 0;
    idle_pct_out = 0;
    queue_random(100, 2);
    wait_drained();
    idle_pct_in = 29;
    idle_pct_out = 29;
    set_length(10'd16);
    queue_random(100, 1);
    // Receiver holds off while the sender keeps offering
    wait_drained();
    hold_off = 2000;
    queue_random(60, 0);
    set_length(10'd2);
    queue_random(60, 3);
    // Sender pause until every result is in
    repeat (100) @(posedge clk);
    sender_pause = 1;
    wait_results();
    sender_pause = 0;
    set_length(10'd33);
    queue_random(100, 1);
    set_length(10'd5);
    queue_random(100, 5);
    set_length(10'd64);
    queue_random(100, 1);

    wait_drained();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+sv
sv/blc_pkg.sv
sv/block_linear_complexity_classifier.sv
tb/sv/tb_block_linear_complexity_classifier.sv
